[src/triangle_point_locator_defines.svh]
// assertion macros for the triangle point locator
`ifndef TRIANGLE_POINT_LOCATOR_DEFINES_SVH
`define TRIANGLE_POINT_LOCATOR_DEFINES_SVH
`ifndef SYNTH
`define TPL_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("triangle_point_locator assertion failed");
`define TPL_NEVER(lbl, expr) lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
   else $error("triangle_point_locator forbidden condition");
`else
`define TPL_ASSERT(lbl, prop)
`define TPL_NEVER(lbl, expr)
`endif
`endif

[src/tpl_pkg.sv]
// shared constants and types for the triangle point locator
package tpl_pkg;
   localparam int DefMaxVertices  = 1024;
   localparam int DefMaxTriangles = 1024;
   localparam int DefCoordWidth   = 32;

   typedef enum logic [1:0] {
      OP_VERTEX   = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_QUERY    = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;
endpackage

[src/triangle_point_locator.sv]
// point location in a triangle mesh with a last-hit cache
//
// Loads vertices (opcode 0) and triangles (opcode 1) into on-chip stores and
// answers point queries (opcode 2) with an enclosing triangle. One beat
// is worked at a time; req_stall is high until the beat is finished and, for a
// query, until the result beat has been taken on the rsp channel. A triangle
// write reads its three corners one per cycle from the vertex store, which
// has a single read port, and stores its bounding box.
// A query tries the cached last-hit triangle first; if that does not enclose
// the point, it scans triangles 0..triangle_count-1 for the first that does.
// The exact test runs on the serial corner reads and one shared signed
// multiplier that forms the six cross product terms one per cycle. Query time
// is therefore data dependent: it grows with the triangles rejected by their
// bounding box and those that reach the exact test, plus the result handshake.
// Boundary points count as inside, degenerate triangles never match. Any
// load or csr write drops the cache. The stores are not cleared at reset.
`include "triangle_point_locator_defines.svh"
module triangle_point_locator
   import tpl_pkg::*;
#(
   parameter int MAX_VERTICES  = DefMaxVertices,
   parameter int MAX_TRIANGLES = DefMaxTriangles,
   parameter int COORD_WIDTH   = DefCoordWidth
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [9:0]         req_slot,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic [9:0]         req_corner_a,
   input  logic [9:0]         req_corner_b,
   input  logic [9:0]         req_corner_c,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [9:0]         rsp_triangle_index,
   // csr write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_triangle_count
);
   localparam int CW   = COORD_WIDTH;
   localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TAW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNTW = $clog2(MAX_TRIANGLES + 1);
   localparam int DW   = CW + 1;        // coordinate differences
   localparam int PW   = 2 * DW;        // one cross product term
   localparam int AW   = PW + 2;        // accumulated cross product
   localparam int FW   = AW + 2;        // final edge sum

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_BOX, ST_VA, ST_VB, ST_VC, ST_VD,
      ST_DIFF, ST_MUL, ST_DEC, ST_WR, ST_OUT
   } state_type;

   // storage
   logic [2*CW-1:0] vtx_mem [MAX_VERTICES];
   logic [29:0]     crn_mem [MAX_TRIANGLES];
   logic [4*CW-1:0] box_mem [MAX_TRIANGLES];
   logic [2*CW-1:0] vtx_rd_ff;
   logic [29:0]     crn_rd_ff;
   logic [4*CW-1:0] box_rd_ff;

   state_type              state_ff, state_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic [TAW-1:0]         last_hit_ff, last_hit_in;
   logic                   hit_valid_ff, hit_valid_in;
   logic                   cache_chk_ff, cache_chk_in;
   logic                   is_query_ff, is_query_in;
   logic [CNTW-1:0]        t_ff, t_in;
   logic [9:0]             slot_ff, slot_in;
   logic [9:0]             ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic signed [CW-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0]   x0_ff, x0_in, y0_ff, y0_in;
   logic signed [CW-1:0]   x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CW-1:0]   x2_ff, x2_in, y2_ff, y2_in;
   logic signed [DW-1:0]   a11_ff, a11_in, a12_ff, a12_in;
   logic signed [DW-1:0]   a21_ff, a21_in, a22_ff, a22_in;
   logic signed [DW-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [2:0]             step_ff, step_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [AW-1:0]   det_ff, det_in, n1_ff, n1_in, n2_ff, n2_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [9:0]             index_ff, index_in;

   logic                   req_take, csr_take;
   logic [TAW-1:0]         tri_raddr;
   logic [VAW-1:0]         vtx_raddr;
   logic                   vtx_we, tri_we;
   logic signed [DW-1:0]   mul_a, mul_b;
   logic signed [AW-1:0]   prod_ext;
   logic signed [CW-1:0]   bx_lo, bx_hi, by_lo, by_hi;
   logic                   box_hit;
   logic signed [FW-1:0]   sdet, sn1, sn2, slack;
   logic                   enclosed;
   logic signed [CW-1:0]   xmin, xmax, ymin, ymax;
   logic                   a_ok, b_ok, c_ok;

   assign req_stall          = (state_ff != ST_IDLE);
   assign csr_ready          = (state_ff == ST_IDLE);
   assign req_take           = req_valid && !req_stall;
   assign csr_take           = csr_valid && csr_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_triangle_index = index_ff;

   // corners beyond the vertex store read as the origin
   assign a_ok = 32'(ca_ff) < 32'(MAX_VERTICES);
   assign b_ok = 32'(cb_ff) < 32'(MAX_VERTICES);
   assign c_ok = 32'(cc_ff) < 32'(MAX_VERTICES);

   // cached triangle is read while the cache check runs, else the scan index
   assign tri_raddr = cache_chk_ff ? last_hit_ff : TAW'(t_ff);

   always_comb begin
      unique case (state_ff)
         ST_VB:   vtx_raddr = VAW'(cb_ff);
         ST_VC:   vtx_raddr = VAW'(cc_ff);
         default: vtx_raddr = VAW'(ca_ff);
      endcase
   end

   assign vtx_we = req_take && (opcode_type'(req_opcode) == OP_VERTEX) &&
                   (32'(req_slot) < 32'(MAX_VERTICES));
   assign tri_we = (state_ff == ST_WR);

   // vertex store: {x, y}
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[VAW'(req_slot)] <= {req_coord_x[CW-1:0], req_coord_y[CW-1:0]};
      end
      vtx_rd_ff <= vtx_mem[vtx_raddr];
   end

   // box extents from the three corners of a triangle being loaded
   always_comb begin
      xmin = (x0_ff < x1_ff) ? x0_ff : x1_ff;
      xmin = (xmin < x2_ff) ? xmin : x2_ff;
      xmax = (x0_ff > x1_ff) ? x0_ff : x1_ff;
      xmax = (xmax > x2_ff) ? xmax : x2_ff;
      ymin = (y0_ff < y1_ff) ? y0_ff : y1_ff;
      ymin = (ymin < y2_ff) ? ymin : y2_ff;
      ymax = (y0_ff > y1_ff) ? y0_ff : y1_ff;
      ymax = (ymax > y2_ff) ? ymax : y2_ff;
   end

   // triangle stores: corners and {xmin, xmax, ymin, ymax}
   always_ff @(posedge clock) begin
      if (tri_we) begin
         crn_mem[TAW'(slot_ff)] <= {cc_ff, cb_ff, ca_ff};
         box_mem[TAW'(slot_ff)] <= {xmin, xmax, ymin, ymax};
      end
      crn_rd_ff <= crn_mem[tri_raddr];
      box_rd_ff <= box_mem[tri_raddr];
   end

   assign bx_lo = box_rd_ff[4*CW-1:3*CW];
   assign bx_hi = box_rd_ff[3*CW-1:2*CW];
   assign by_lo = box_rd_ff[2*CW-1:CW];
   assign by_hi = box_rd_ff[CW-1:0];
   assign box_hit = (px_ff >= bx_lo) && (px_ff <= bx_hi) &&
                    (py_ff >= by_lo) && (py_ff <= by_hi);

   // shared multiplier operand select, one cross product term per step
   always_comb begin
      unique case (step_ff)
         3'd0:    begin mul_a = a11_ff; mul_b = a22_ff; end
         3'd1:    begin mul_a = a21_ff; mul_b = a12_ff; end
         3'd2:    begin mul_a = a22_ff; mul_b = dx_ff;  end
         3'd3:    begin mul_a = a21_ff; mul_b = dy_ff;  end
         3'd4:    begin mul_a = a11_ff; mul_b = dy_ff;  end
         default: begin mul_a = a12_ff; mul_b = dx_ff;  end
      endcase
   end
   assign prod_in  = PW'(mul_a * mul_b);
   assign prod_ext = AW'(prod_ff);

   // exact inside-or-on test, orientation corrected
   always_comb begin
      if (det_ff < 0) begin
         sdet = -FW'(det_ff);
         sn1  = -FW'(n1_ff);
         sn2  = -FW'(n2_ff);
      end else begin
         sdet = FW'(det_ff);
         sn1  = FW'(n1_ff);
         sn2  = FW'(n2_ff);
      end
      slack    = sdet - sn1 - sn2;
      enclosed = (det_ff != 0) && (sn1 >= 0) && (sn2 >= 0) && (slack >= 0);
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_hit_in  = last_hit_ff;
      hit_valid_in = hit_valid_ff;
      cache_chk_in = cache_chk_ff;
      is_query_in  = is_query_ff;
      t_in         = t_ff;
      slot_in      = slot_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      cc_in        = cc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      a11_in       = a11_ff;
      a12_in       = a12_ff;
      a21_in       = a21_ff;
      a22_in       = a22_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      step_in      = step_ff;
      det_in       = det_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      index_in     = index_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               // count saturates at the triangle store depth
               if (32'(csr_triangle_count) > 32'(MAX_TRIANGLES)) begin
                  count_in = CNTW'(MAX_TRIANGLES);
               end else begin
                  count_in = CNTW'(csr_triangle_count);
               end
               hit_valid_in = 1'b0;
            end
            if (req_take) begin
               slot_in = req_slot;
               ca_in   = req_corner_a;
               cb_in   = req_corner_b;
               cc_in   = req_corner_c;
               px_in   = req_coord_x[CW-1:0];
               py_in   = req_coord_y[CW-1:0];
               unique case (opcode_type'(req_opcode))
                  OP_VERTEX: begin
                     hit_valid_in = 1'b0;
                  end
                  OP_TRIANGLE: begin
                     hit_valid_in = 1'b0;
                     is_query_in  = 1'b0;
                     if (32'(req_slot) < 32'(MAX_TRIANGLES)) begin
                        state_in = ST_VA;
                     end
                  end
                  OP_QUERY: begin
                     is_query_in  = 1'b1;
                     // a csr write in the same cycle drops the cache first
                     cache_chk_in = hit_valid_ff && !csr_take;
                     t_in         = '0;
                     state_in     = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // store read of the addressed triangle is issued here
            if (cache_chk_ff || (t_ff < count_ff)) begin
               state_in = ST_BOX;
            end else begin
               hit_valid_in = 1'b0;
               found_in     = 1'b0;
               index_in     = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_BOX: begin
            ca_in = crn_rd_ff[9:0];
            cb_in = crn_rd_ff[19:10];
            cc_in = crn_rd_ff[29:20];
            // the cached triangle skips the box test, its box may predate the hit
            if (cache_chk_ff || box_hit) begin
               state_in = ST_VA;
            end else begin
               t_in     = CNTW'(t_ff + 1'b1);
               state_in = ST_SCAN;
            end
         end
         ST_VA: state_in = ST_VB;
         ST_VB: begin
            x0_in    = a_ok ? vtx_rd_ff[2*CW-1:CW] : '0;
            y0_in    = a_ok ? vtx_rd_ff[CW-1:0]    : '0;
            state_in = ST_VC;
         end
         ST_VC: begin
            x1_in    = b_ok ? vtx_rd_ff[2*CW-1:CW] : '0;
            y1_in    = b_ok ? vtx_rd_ff[CW-1:0]    : '0;
            state_in = ST_VD;
         end
         ST_VD: begin
            x2_in    = c_ok ? vtx_rd_ff[2*CW-1:CW] : '0;
            y2_in    = c_ok ? vtx_rd_ff[CW-1:0]    : '0;
            state_in = is_query_ff ? ST_DIFF : ST_WR;
         end
         ST_WR: state_in = ST_IDLE;
         ST_DIFF: begin
            a11_in   = DW'(x1_ff) - DW'(x0_ff);
            a12_in   = DW'(y1_ff) - DW'(y0_ff);
            a21_in   = DW'(x2_ff) - DW'(x0_ff);
            a22_in   = DW'(y2_ff) - DW'(y0_ff);
            dx_in    = DW'(px_ff) - DW'(x0_ff);
            dy_in    = DW'(py_ff) - DW'(y0_ff);
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // product of step k is registered and folded in at step k+1
            unique case (step_ff)
               3'd1:    det_in = prod_ext;
               3'd2:    det_in = det_ff - prod_ext;
               3'd3:    n1_in  = prod_ext;
               3'd4:    n1_in  = n1_ff - prod_ext;
               3'd5:    n2_in  = prod_ext;
               3'd6:    n2_in  = n2_ff - prod_ext;
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (enclosed) begin
               hit_valid_in = 1'b1;
               last_hit_in  = tri_raddr;
               found_in     = 1'b1;
               index_in     = 10'(tri_raddr);
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else if (cache_chk_ff) begin
               cache_chk_in = 1'b0;
               t_in         = '0;
               state_in     = ST_SCAN;
            end else begin
               t_in     = CNTW'(t_ff + 1'b1);
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_hit_ff  <= '0;
         hit_valid_ff <= 1'b0;
         cache_chk_ff <= 1'b0;
         is_query_ff  <= 1'b0;
         t_ff         <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_hit_ff  <= last_hit_in;
         hit_valid_ff <= hit_valid_in;
         cache_chk_ff <= cache_chk_in;
         is_query_ff  <= is_query_in;
         t_ff         <= t_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff  <= slot_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
      cc_ff    <= cc_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      x2_ff    <= x2_in;
      y2_ff    <= y2_in;
      a11_ff   <= a11_in;
      a12_ff   <= a12_in;
      a21_ff   <= a21_in;
      a22_ff   <= a22_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      prod_ff  <= prod_in;
      det_ff   <= det_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   // a pending result keeps the request side closed
   `TPL_ASSERT(a_rsp_blocks_req, rsp_valid |-> req_stall)
   // a miss reports index zero
   `TPL_ASSERT(a_miss_index_zero, (rsp_valid && !rsp_found) |-> (rsp_triangle_index == 10'd0))
   // a cached triangle always lies within the scanned range
   `TPL_ASSERT(a_cache_in_range, hit_valid_ff |-> (CNTW'(last_hit_ff) < count_ff))
   // a result beat is never raised while csr writes are open
   `TPL_NEVER(a_no_rsp_when_idle, rsp_valid_ff && (state_ff == ST_IDLE))
endmodule
